FILE: hw/rtl/ilpdr_pkg.sv
// ----------------------------------------------------------------------------
// ilpdr_pkg
// Field widths and codes shared by the idle-line packet descriptor ring.
// ----------------------------------------------------------------------------
package ilpdr_pkg;

  // Input transaction fields
  localparam int MODE_W    = 1;
  localparam int DMA_REM_W = 12;
  localparam int REL_W     = 8;

  // Result transaction fields
  localparam int SLOT_OUT_W = 4;
  localparam int POS_OUT_W  = 11;

  // Item kinds carried on the mode field
  localparam logic [MODE_W-1:0] MODE_IDLE    = 1'b0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 1'b1;

endpackage

FILE: hw/rtl/ilpdr_frame_calc.sv
// ----------------------------------------------------------------------------
// ilpdr_frame_calc
// Position arithmetic for one idle event: write position from the DMA
// remaining count, bytes since the previous event, end offset and the new
// running byte count, all modulo the buffer size.
// ----------------------------------------------------------------------------
module ilpdr_frame_calc #(
  parameter int BUF_SIZE = 2048
) (
  input  logic [ilpdr_pkg::DMA_REM_W-1:0] dma_remaining,
  input  logic [$clog2(BUF_SIZE)-1:0]     last_position,
  input  logic [$clog2(BUF_SIZE)-1:0]     byte_counter,
  output logic [$clog2(BUF_SIZE)-1:0]     cur_pos,
  output logic [$clog2(BUF_SIZE)-1:0]     recv,
  output logic [$clog2(BUF_SIZE)-1:0]     end_calc,
  output logic [$clog2(BUF_SIZE)-1:0]     byte_next
);
  import ilpdr_pkg::*;

  localparam int POS_W = $clog2(BUF_SIZE);
  localparam int CNT_W = $clog2(BUF_SIZE + 1);
  localparam int CMP_W = (CNT_W > DMA_REM_W) ? CNT_W : DMA_REM_W;
  localparam int EXT_W = POS_W + 1;

  logic [CNT_W-1:0] rem_sat;
  logic [CNT_W-1:0] fill;
  logic [EXT_W-1:0] cur_e;
  logic [EXT_W-1:0] last_e;
  logic [EXT_W-1:0] recv_e;
  logic [EXT_W-1:0] end_sum;
  logic [EXT_W-1:0] byte_sum;

  // Saturate the remaining count and derive the write position
  assign rem_sat = (CMP_W'(dma_remaining) > CMP_W'(BUF_SIZE)) ? CNT_W'(BUF_SIZE)
                                                             : CNT_W'(dma_remaining);
  assign fill    = CNT_W'(BUF_SIZE) - rem_sat;
  assign cur_pos = (fill == CNT_W'(BUF_SIZE)) ? '0 : POS_W'(fill);

  // Bytes since the previous event, with wrap
  assign cur_e  = EXT_W'(cur_pos);
  assign last_e = EXT_W'(last_position);
  assign recv_e = (cur_e >= last_e) ? (cur_e - last_e)
                                    : (EXT_W'(BUF_SIZE) - last_e + cur_e);
  assign recv   = POS_W'(recv_e);

  // Offset of the last byte of the packet
  assign end_sum  = last_e + recv_e - EXT_W'(1);
  assign end_calc = (end_sum >= EXT_W'(BUF_SIZE)) ? POS_W'(end_sum - EXT_W'(BUF_SIZE))
                                                  : POS_W'(end_sum);

  // Running byte count modulo the buffer size
  assign byte_sum  = EXT_W'(byte_counter) + recv_e;
  assign byte_next = (byte_sum >= EXT_W'(BUF_SIZE)) ? POS_W'(byte_sum - EXT_W'(BUF_SIZE))
                                                    : POS_W'(byte_sum);

endmodule

FILE: hw/rtl/idle_line_packet_descriptor_ring_unit.sv
// ----------------------------------------------------------------------------
// idle_line_packet_descriptor_ring_unit
// Packet framing over a circular receive buffer, one descriptor per idle event with new bytes.
// ----------------------------------------------------------------------------
// Each input transaction is either a line-idle event (mode 0, carrying the DMA
// remaining count) or a slot release (mode 1). An idle event that finds new
// bytes writes the start and end offsets into the current descriptor slot,
// marks it valid, discards the following slot if it is still valid so that
// one slot always stays free, and advances the write slot; every item returns
// exactly one result transaction with the slot indices and the running byte
// total after it. After an input transaction is accepted, the update state
// does the position arithmetic and the slot and index update (with the
// descriptor memory write), the read state reads the descriptor memory into
// a data register, and the done state loads the result register.
// The input stalls from acceptance until the result is loaded, so the block
// takes no new item while one is in flight. A previous result still held
// by the receiver holds the current item in its done state, and so the
// input, until that result is taken. Slot valid marks sit in
// flip-flops cleared by reset, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module idle_line_packet_descriptor_ring_unit #(
  parameter int BUF_SIZE = 2048,
  parameter int SLOTS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ilpdr_pkg::MODE_W-1:0]     mode,
  input  logic [ilpdr_pkg::DMA_REM_W-1:0]  dma_remaining,
  input  logic [ilpdr_pkg::REL_W-1:0]      release_slot,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             packet_recorded,
  output logic [ilpdr_pkg::SLOT_OUT_W-1:0] packet_slot,
  output logic [ilpdr_pkg::POS_OUT_W-1:0]  start_pos,
  output logic [ilpdr_pkg::POS_OUT_W-1:0]  end_pos,
  output logic [ilpdr_pkg::POS_OUT_W-1:0]  packet_length,
  output logic                             overwrote_oldest,
  output logic [ilpdr_pkg::SLOT_OUT_W-1:0] read_slot,
  output logic [ilpdr_pkg::SLOT_OUT_W-1:0] write_slot,
  output logic [ilpdr_pkg::POS_OUT_W-1:0]  byte_total
);
  import ilpdr_pkg::*;

  localparam int POS_W   = $clog2(BUF_SIZE);
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int REL_C_W = REL_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_DONE
  } state_t;

  state_t state;

  // Ring state
  logic [SLOTS-1:0]   slot_valid;
  logic [IDX_W-1:0]   write_index;
  logic [IDX_W-1:0]   read_index;
  logic [POS_W-1:0]   last_position;
  logic [POS_W-1:0]   byte_counter;

  // Descriptor memory: {start, end} per slot
  logic [2*POS_W-1:0] desc_mem [SLOTS];
  logic [2*POS_W-1:0] rd_data;

  // Captured transaction and per-item results
  logic [MODE_W-1:0]    mode_q;
  logic [DMA_REM_W-1:0] rem_q;
  logic [REL_W-1:0]     rel_q;
  logic                 rec_q;
  logic                 over_q;
  logic [IDX_W-1:0]     pslot_q;
  logic [POS_W-1:0]     plen_q;

  // Arithmetic results
  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] recv;
  logic [POS_W-1:0] end_calc;
  logic [POS_W-1:0] byte_next;

  logic             rec_now;
  logic             rel_ok;
  logic [IDX_W-1:0] rel_idx;
  logic [IDX_W-1:0] wr_nx;
  logic [IDX_W-1:0] rd_nx;
  logic             load_out;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(SLOTS - 1)) ? '0 : s + IDX_W'(1);
  endfunction

  ilpdr_frame_calc #(
    .BUF_SIZE (BUF_SIZE)
  ) u_calc (
    .dma_remaining (rem_q),
    .last_position (last_position),
    .byte_counter  (byte_counter),
    .cur_pos       (cur_pos),
    .recv          (recv),
    .end_calc      (end_calc),
    .byte_next     (byte_next)
  );

  // Decode the captured item
  assign rec_now = (mode_q == MODE_IDLE) && (recv != '0);
  assign rel_ok  = REL_C_W'(rel_q) < REL_C_W'(SLOTS);
  assign rel_idx = IDX_W'(rel_q);
  assign wr_nx   = idx_next(write_index);
  assign rd_nx   = idx_next(read_index);

  // Load the result once the previous transaction has gone
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // Take a new item only between items
  assign in_stall = (state != ST_IDLE);

  // Control, ring state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      slot_valid    <= '0;
      write_index   <= '0;
      read_index    <= '0;
      last_position <= '0;
      byte_counter  <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            rem_q  <= dma_remaining;
            rel_q  <= release_slot;
            state  <= ST_CALC;
          end
        end
        ST_CALC: begin
          rec_q   <= rec_now;
          over_q  <= rec_now && slot_valid[wr_nx];
          pslot_q <= rec_now ? write_index : '0;
          plen_q  <= rec_now ? recv : '0;
          if (mode_q == MODE_RELEASE) begin
            // Release: drop the mark; if it was the oldest slot, advance the oldest pointer past it
            if (rel_ok) begin
              slot_valid[rel_idx] <= 1'b0;
              if (rel_idx == read_index) begin
                read_index <= rd_nx;
              end
            end
          end else begin
            last_position <= cur_pos;
            if (rec_now) begin
              // Mark the new slot and keep the following one free
              slot_valid   <= (slot_valid | (SLOTS'(1) << write_index))
                              & ~(SLOTS'(1) << wr_nx);
              byte_counter <= byte_next;
              write_index  <= wr_nx;
              if (slot_valid[wr_nx] && (wr_nx == read_index)) begin
                read_index <= rd_nx;
              end
            end
          end
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            packet_recorded  <= rec_q;
            packet_slot      <= SLOT_OUT_W'(pslot_q);
            start_pos        <= rec_q ? POS_OUT_W'(rd_data[2*POS_W-1:POS_W]) : '0;
            end_pos          <= rec_q ? POS_OUT_W'(rd_data[POS_W-1:0]) : '0;
            packet_length    <= POS_OUT_W'(plen_q);
            overwrote_oldest <= over_q;
            read_slot        <= SLOT_OUT_W'(read_index);
            write_slot       <= SLOT_OUT_W'(write_index);
            byte_total       <= POS_OUT_W'(byte_counter);
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Descriptor memory: write on record, read back the recorded slot
  always_ff @(posedge clk) begin
    if (state == ST_CALC && rec_now) begin
      desc_mem[write_index] <= {last_position, end_calc};
    end
    if (state == ST_READ) begin
      rd_data <= desc_mem[pslot_q];
    end
  end

  // The slot under the write pointer is always free
  a_write_slot_free : assert property (@(posedge clk) disable iff (rst)
    !slot_valid[write_index])
    else $error("write slot holds a valid descriptor");

  // A recorded packet leaves its slot marked valid
  a_record_marks : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && rec_now) |=> slot_valid[pslot_q])
    else $error("recorded slot not marked valid");

  // Ring pointers move only during the update cycle
  a_ptr_hold : assert property (@(posedge clk) disable iff (rst)
    (state != ST_CALC) |=> ($stable(read_index) && $stable(write_index)))
    else $error("ring pointer moved outside the update cycle");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the idle-line packet descriptor ring.
// ----------------------------------------------------------------------------
// Drives line-idle events and slot releases into the ring. A directed opening
// covers empty events, saturated counts, wrap and out-of-range releases, and a
// full pass of the ring. Random traffic follows: it is mostly forward-moving
// receive positions and releases of the oldest slot. A tracker class models
// the descriptor ring and compares every result transaction field by field.
// The sender works in bursts, and the receiver stalls on its own pattern,
// including one long hold-off that backs the ring up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ilpdr_pkg::*;

  localparam int RING_BYTES = 2048;
  localparam int RING_SLOTS = 16;
  localparam int RANDOM_EVENTS = 550;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_LEN = 120;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [DMA_REM_W-1:0] dma_rem;
    logic [REL_W-1:0]     rel;
  } ring_item_t;

  typedef struct packed {
    logic                  recorded;
    logic [SLOT_OUT_W-1:0] slot;
    logic [POS_OUT_W-1:0]  first_pos;
    logic [POS_OUT_W-1:0]  last_pos;
    logic [POS_OUT_W-1:0]  length;
    logic                  overwrote;
    logic [SLOT_OUT_W-1:0] rd;
    logic [SLOT_OUT_W-1:0] wr;
    logic [POS_OUT_W-1:0]  total;
  } ring_report_t;

  // Descriptor ring tracker: holds its own ring state and the reports due
  class ring_tracker;
    bit           slot_live[RING_SLOTS];
    int unsigned  wr_idx;
    int unsigned  rd_idx;
    int unsigned  rx_pos;
    int unsigned  byte_count;
    ring_report_t pending_reports[$];
    int           errors;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      wr_idx = 0;
      rd_idx = 0;
      rx_pos = 0;
      byte_count = 0;
      errors = 0;
    endfunction

    // Advance the ring for one accepted item and queue the report it causes
    function void take_event(ring_item_t it);
      ring_report_t rep;
      int unsigned  remain;
      int unsigned  cur;
      int unsigned  recv;
      int unsigned  nxt;
      rep = '0;
      if (it.mode == MODE_RELEASE) begin
        if (it.rel < RING_SLOTS) begin
          slot_live[it.rel] = 1'b0;
          if (it.rel == rd_idx) rd_idx = (rd_idx + 1) % RING_SLOTS;
        end
      end else begin
        remain = 32'(it.dma_rem);
        if (remain > RING_BYTES) remain = RING_BYTES;
        cur = (RING_BYTES - remain) % RING_BYTES;
        recv = (cur >= rx_pos) ? cur - rx_pos : RING_BYTES - rx_pos + cur;
        if (recv != 0) begin
          nxt = (wr_idx + 1) % RING_SLOTS;
          slot_live[wr_idx] = 1'b1;
          rep.recorded  = 1'b1;
          rep.slot      = SLOT_OUT_W'(wr_idx);
          rep.first_pos = POS_OUT_W'(rx_pos);
          rep.last_pos  = POS_OUT_W'((rx_pos + recv - 1) % RING_BYTES);
          rep.length    = POS_OUT_W'(recv);
          byte_count = (byte_count + recv) % RING_BYTES;
          // Keep one slot free: drop the following descriptor if still live
          if (slot_live[nxt]) begin
            slot_live[nxt] = 1'b0;
            rep.overwrote = 1'b1;
            if (nxt == rd_idx) rd_idx = (rd_idx + 1) % RING_SLOTS;
          end
          wr_idx = nxt;
        end
        rx_pos = cur;
      end
      rep.rd    = SLOT_OUT_W'(rd_idx);
      rep.wr    = SLOT_OUT_W'(wr_idx);
      rep.total = POS_OUT_W'(byte_count);
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Check one result transaction against the oldest report due
    function void match_report(ring_report_t got);
      ring_report_t exp;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp = pending_reports.pop_front();
      compare_field("packet_recorded", 32'(exp.recorded), 32'(got.recorded));
      compare_field("packet_slot", 32'(exp.slot), 32'(got.slot));
      compare_field("start_pos", 32'(exp.first_pos), 32'(got.first_pos));
      compare_field("end_pos", 32'(exp.last_pos), 32'(got.last_pos));
      compare_field("packet_length", 32'(exp.length), 32'(got.length));
      compare_field("overwrote_oldest", 32'(exp.overwrote), 32'(got.overwrote));
      compare_field("read_slot", 32'(exp.rd), 32'(got.rd));
      compare_field("write_slot", 32'(exp.wr), 32'(got.wr));
      compare_field("byte_total", 32'(exp.total), 32'(got.total));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     mode;
  logic [DMA_REM_W-1:0]  dma_remaining;
  logic [REL_W-1:0]      release_slot;
  logic                  out_valid;
  logic                  out_stall;
  logic                  packet_recorded;
  logic [SLOT_OUT_W-1:0] packet_slot;
  logic [POS_OUT_W-1:0]  start_pos;
  logic [POS_OUT_W-1:0]  end_pos;
  logic [POS_OUT_W-1:0]  packet_length;
  logic                  overwrote_oldest;
  logic [SLOT_OUT_W-1:0] read_slot;
  logic [SLOT_OUT_W-1:0] write_slot;
  logic [POS_OUT_W-1:0]  byte_total;

  ring_tracker tracker;
  int unsigned cycle_count;
  int unsigned quiet_cycles;

  idle_line_packet_descriptor_ring_unit #(
    .BUF_SIZE(RING_BYTES),
    .SLOTS   (RING_SLOTS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .dma_remaining   (dma_remaining),
    .release_slot    (release_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .packet_recorded (packet_recorded),
    .packet_slot     (packet_slot),
    .start_pos       (start_pos),
    .end_pos         (end_pos),
    .packet_length   (packet_length),
    .overwrote_oldest(overwrote_oldest),
    .read_slot       (read_slot),
    .write_slot      (write_slot),
    .byte_total      (byte_total)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Present one transaction and hold it until the ring takes it
  task automatic send_item(input ring_item_t it);
    @(negedge clk);
    in_valid      <= 1'b1;
    mode          <= it.mode;
    dma_remaining <= it.dma_rem;
    release_slot  <= it.rel;
    do @(posedge clk); while (in_stall);
    tracker.take_event(it);
  endtask

  // Drop valid for a number of cycles, with noise on the payload
  task automatic pause_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      mode          <= MODE_W'($urandom);
      dma_remaining <= DMA_REM_W'($urandom);
      release_slot  <= REL_W'($urandom);
    end
  endtask

  function automatic ring_item_t idle_at(input int unsigned pos, input bit use_zero);
    ring_item_t it;
    it.mode = MODE_IDLE;
    it.rel  = REL_W'($urandom);
    it.dma_rem = (pos == 0 && use_zero) ? '0 : DMA_REM_W'(RING_BYTES - pos);
    return it;
  endfunction

  function automatic ring_item_t release_of(input int unsigned slot);
    ring_item_t it;
    it.mode    = MODE_RELEASE;
    it.dma_rem = DMA_REM_W'($urandom);
    it.rel     = REL_W'(slot);
    return it;
  endfunction

  // Mostly forward-moving positions and oldest-slot releases, some noise
  function automatic ring_item_t pick_item();
    int unsigned pick;
    int unsigned delta;
    ring_item_t  it;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      delta = ($urandom_range(0, 9) == 0) ? $urandom_range(65, RING_BYTES - 1)
                                          : $urandom_range(1, 64);
      it = idle_at((tracker.rx_pos + delta) % RING_BYTES, 1'($urandom_range(0, 1)));
    end else if (pick < 52) begin
      it = idle_at(tracker.rx_pos, 1'($urandom_range(0, 1)));
    end else if (pick < 60) begin
      it = idle_at(0, 1'b0);
      it.dma_rem = DMA_REM_W'($urandom_range(0, (1 << DMA_REM_W) - 1));
    end else if (pick < 82) begin
      it = release_of(tracker.rd_idx);
    end else if (pick < 94) begin
      it = release_of($urandom_range(0, RING_SLOTS - 1));
    end else begin
      it = release_of($urandom_range(0, (1 << REL_W) - 1));
    end
    return it;
  endfunction

  // Check each result transaction as it is taken
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.match_report({packet_recorded, packet_slot, start_pos, end_pos,
                            packet_length, overwrote_oldest, read_slot,
                            write_slot, byte_total});
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver stall pattern, with one long hold-off counted here
  initial begin
    int unsigned kind;
    out_stall = 1'b0;
    cycle_count = 0;
    kind = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (cycle_count % 40 == 0) kind = $urandom_range(0, 3);
      if (cycle_count >= LONG_HOLD_AT && cycle_count < LONG_HOLD_AT + LONG_HOLD_LEN) begin
        out_stall <= 1'b1;
      end else begin
        case (kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= cycle_count[0];
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
      cycle_count++;
      @(negedge clk);
    end
  end

  // Reset, directed opening, random bursts, drain
  initial begin
    int unsigned burst;
    int unsigned sent;
    tracker       = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = MODE_IDLE;
    dma_remaining = '0;
    release_slot  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty events: full remaining count and zero remaining both mean position 0; then a one-byte packet
    send_item(idle_at(0, 1'b0));
    send_item(idle_at(0, 1'b1));
    send_item(idle_at(1, 1'b0));
    // Saturated count wraps all the way round to position 0
    send_item(idle_at(0, 1'b0) | ring_item_t'({MODE_IDLE, 12'hFFF, 8'h00}));
    send_item(idle_at(1000, 1'b0));
    send_item(idle_at(1000, 1'b0));
    // Out-of-range, non-oldest and oldest releases
    send_item(release_of(255));
    send_item(release_of(RING_SLOTS));
    send_item(release_of(1));
    send_item(release_of(0));
    // Run the write slot round the ring so live slots get discarded
    for (int k = 0; k < RING_SLOTS; k++) begin
      send_item(idle_at((tracker.rx_pos + 97 + k) % RING_BYTES, 1'b0));
    end
    pause_sender(4);

    // Random traffic in bursts
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_EVENTS; b++) begin
        send_item(pick_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    pause_sender(1);

    // Drain outstanding reports, then allow for the pipeline
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
